// ===== rtl/mpd_pkg.sv =====
// Shared constants, types and word layout for the multicast provisioning decoder.
package mpd_pkg;

    localparam int DEF_MAX_SLOT_INDEX = 127;
    localparam logic [6:0] MAX_TEXT_LEN = 7'd64;
    localparam int SCAN_GROUP = 16;
    localparam int FIRST_SLOT = 4;

    localparam logic [47:0] KEY_A = 48'h01005E004835;
    localparam logic [47:0] KEY_B = 48'h01005E01682B;
    localparam logic [47:0] KEY_C = 48'h01005E025C31;
    localparam logic [31:0] LEN_PREFIX = 32'h01005E03;
    localparam logic [23:0] SLOT_PREFIX = 24'h01005E;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam int IN_W = 176;
    localparam int OUT_W = 56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_JOIN,
        ST_FIN
    } st_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic scan_en;
    } slot_ctl_t;

endpackage

// ===== rtl/mpd_slot_store.sv =====
// Slot word memory, slot valid bits and registered completion scan.
module mpd_slot_store
    import mpd_pkg::*;
#(
    parameter int SLOT_DEPTH = DEF_MAX_SLOT_INDEX + 1,
    localparam int SLOT_AW = $clog2(SLOT_DEPTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  slot_ctl_t          ctl,
    input  logic [SLOT_AW-1:0] wr_addr,
    input  logic [15:0]        wr_data,
    input  logic [SLOT_AW-1:0] rd_addr,
    input  logic [6:0]         scan_len,
    output logic [15:0]        rd_q,
    output logic               rd_vld_q,
    output logic               scan_ok
);

    localparam int GROUPS = (SLOT_DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int PAD = GROUPS * SCAN_GROUP;

    logic [15:0]           mem [SLOT_DEPTH];
    logic [15:0]           rd_q_reg;
    logic                  rd_vld_reg;
    logic [SLOT_DEPTH-1:0] valid_reg;
    logic [GROUPS-1:0]     group_ok_reg;
    logic [GROUPS-1:0]     group_ok_next;
    logic                  len_nz_reg;
    logic                  fits_reg;
    logic [PAD-1:0]        vld_pad;
    logic [PAD-1:0]        need;
    logic [7:0]            len_end;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            group_ok_reg <= '0;
            len_nz_reg   <= 1'b0;
            fits_reg     <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            if (ctl.scan_en)
            begin
                group_ok_reg <= group_ok_next;
                len_nz_reg   <= (scan_len != 7'd0);
                fits_reg     <= (int'(len_end) <= SLOT_DEPTH);
            end
        end
    end

    always_comb
    begin
        len_end = {1'b0, scan_len} + 8'(FIRST_SLOT);
        vld_pad = '0;
        for (int i = 0; i < SLOT_DEPTH; i++)
        begin
            vld_pad[i] = valid_reg[i];
        end
        for (int i = 0; i < PAD; i++)
        begin
            need[i] = (i >= FIRST_SLOT) && (i < int'(len_end));
        end
        for (int g = 0; g < GROUPS; g++)
        begin
            group_ok_next[g] = &(vld_pad[g*SCAN_GROUP +: SCAN_GROUP]
                                 | ~need[g*SCAN_GROUP +: SCAN_GROUP]);
        end
    end

    assign rd_q     = rd_q_reg;
    assign rd_vld_q = rd_vld_reg;
    assign scan_ok  = len_nz_reg & fits_reg & (&group_ok_reg);

endmodule

// ===== rtl/multicast_provisioning_decoder_core.sv =====
// Top level of the multicast provisioning decoder: frame decode, learning, lock and slot fill.
//
//  channel | dir | words                  | accepted when
//  s_axis  | in  | frame or slot read     | s_axis_tvalid & s_axis_tready
//  m_axis  | out | one status word / item | m_axis_tvalid & m_axis_tready
//
//  A valid locked frame from the learnt source with an in-range slot index, before completion,
//  passes through capture with slot memory read, execute with memory write, completion scan (one
//  registered level over 16-slot groups), combine and result. Any other word skips the
//  scan and combine states.
//  Reset clears all flags, candidates, lengths and slot valid bits at once; no sweep.
//  A new word is taken in the idle cycle even while the last result waits on m_axis.
//  The result stage holds until the output register is free.
module multicast_provisioning_decoder_core
    import mpd_pkg::*;
#(
    parameter int MAX_SLOT_INDEX = DEF_MAX_SLOT_INDEX
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // frame_ok, to_ds, from_ds, address_one, address_two, address_three,
    // frame_channel, read_index, zero fill
    input  logic [IN_W-1:0]  s_axis_tdata,
    // operation
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // locked, retune, tuned_channel, complete, name_length, key_length,
    // read_valid, read_data, zero fill
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int SLOT_DEPTH = MAX_SLOT_INDEX + 1;
    localparam int SLOT_AW = $clog2(SLOT_DEPTH);

    st_t state_reg, state_next;

    logic [IN_W-1:0]  item_reg;
    logic             op_reg;
    logic             lock_flag_reg, lock_flag_next;
    logic             done_flag_reg, done_flag_next;
    logic [47:0]      cand_reg [3];
    logic [47:0]      cand_next [3];
    logic [15:0]      channel_reg, channel_next;
    logic [6:0]       name_len_reg, name_len_next;
    logic [6:0]       key_len_reg, key_len_next;
    logic             pulse_reg, pulse_next;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;

    logic             accept;
    logic             out_load;
    logic             exec_wr;
    logic             exec_check;
    slot_ctl_t        ctl;
    logic [15:0]      rd_q;
    logic             rd_vld_q;
    logic             scan_ok;
    logic [6:0]       scan_len;

    logic             f_ok, f_tods, f_fromds;
    logic [47:0]      f_a1, f_a2, f_a3;
    logic [15:0]      f_chan;
    logic [6:0]       f_ridx;
    logic [47:0]      mc, src;
    logic             sel_ok;
    logic [7:0]       idx;
    logic             rd_in_range;
    logic             rvalid;

    assign f_ok     = item_reg[0];
    assign f_tods   = item_reg[1];
    assign f_fromds = item_reg[2];
    assign f_a1     = item_reg[50:3];
    assign f_a2     = item_reg[98:51];
    assign f_a3     = item_reg[146:99];
    assign f_chan   = item_reg[162:147];
    assign f_ridx   = item_reg[169:163];

    assign accept   = s_axis_tvalid & s_axis_tready;
    assign scan_len = (name_len_reg > key_len_reg) ? name_len_reg : key_len_reg;

    always_comb
    begin
        mc             = f_a3;
        src            = f_a2;
        sel_ok         = 1'b0;
        lock_flag_next = lock_flag_reg;
        channel_next   = channel_reg;
        name_len_next  = name_len_reg;
        key_len_next   = key_len_reg;
        pulse_next     = 1'b0;
        exec_wr        = 1'b0;
        exec_check     = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            cand_next[c] = cand_reg[c];
        end
        if (!f_tods && f_fromds)
        begin
            mc     = f_a1;
            src    = f_a3;
            sel_ok = 1'b1;
        end
        else if (f_tods && !f_fromds)
        begin
            sel_ok = 1'b1;
        end
        idx = mc[23:16];
        if (op_reg == OP_FRAME && f_ok && !done_flag_reg && sel_ok)
        begin
            if (lock_flag_reg)
            begin
                if (src == cand_reg[0] && int'(idx) <= MAX_SLOT_INDEX)
                begin
                    exec_check = 1'b1;
                    if (mc[47:16] == LEN_PREFIX)
                    begin
                        if (mc[15:8] <= {1'b0, MAX_TEXT_LEN}
                            && mc[7:0] <= {1'b0, MAX_TEXT_LEN})
                        begin
                            name_len_next = mc[14:8];
                            key_len_next  = mc[6:0];
                        end
                    end
                    else if (mc[47:24] == SLOT_PREFIX)
                    begin
                        exec_wr = 1'b1;
                    end
                end
            end
            else
            begin
                if (mc == KEY_A)
                begin
                    channel_next = f_chan;
                    cand_next[0] = src;
                end
                if (mc == KEY_B)
                begin
                    channel_next = f_chan;
                    cand_next[1] = src;
                end
                if (mc == KEY_C)
                begin
                    channel_next = f_chan;
                    cand_next[2] = src;
                end
                if (cand_next[0] != 48'd0 && cand_next[1] != 48'd0
                    && cand_next[2] != 48'd0 && cand_next[0] == cand_next[1]
                    && cand_next[2] == cand_next[1])
                begin
                    lock_flag_next = 1'b1;
                    pulse_next     = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        s_axis_tready  = 1'b0;
        ctl            = '0;
        out_load       = 1'b0;
        done_flag_next = done_flag_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ctl.rd_en     = s_axis_tvalid;
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.wr_en  = exec_wr;
                state_next = exec_check ? ST_SCAN : ST_FIN;
            end
            ST_SCAN:
            begin
                ctl.scan_en = 1'b1;
                state_next  = ST_JOIN;
            end
            ST_JOIN:
            begin
                if (scan_ok)
                begin
                    done_flag_next = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= s_axis_tdata;
            op_reg   <= s_axis_tuser;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_flag_reg <= 1'b0;
            done_flag_reg <= 1'b0;
            channel_reg   <= '0;
            name_len_reg  <= '0;
            key_len_reg   <= '0;
            pulse_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                cand_reg[c] <= '0;
            end
        end
        else
        begin
            done_flag_reg <= done_flag_next;
            if (accept)
            begin
                pulse_reg <= 1'b0;
            end
            if (state_reg == ST_EXEC)
            begin
                lock_flag_reg <= lock_flag_next;
                channel_reg   <= channel_next;
                name_len_reg  <= name_len_next;
                key_len_reg   <= key_len_next;
                pulse_reg     <= pulse_next;
                for (int c = 0; c < 3; c++)
                begin
                    cand_reg[c] <= cand_next[c];
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    mpd_slot_store #(
        .SLOT_DEPTH (SLOT_DEPTH)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .wr_addr  (idx[SLOT_AW-1:0]),
        .wr_data  (mc[15:0]),
        .rd_addr  (s_axis_tdata[163 +: SLOT_AW]),
        .scan_len (scan_len),
        .rd_q     (rd_q),
        .rd_vld_q (rd_vld_q),
        .scan_ok  (scan_ok)
    );

    assign rd_in_range = (int'(f_ridx) <= MAX_SLOT_INDEX);
    assign rvalid      = (op_reg == OP_READ) & rd_in_range & rd_vld_q;

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[0]     = lock_flag_reg;
        out_data_next[1]     = pulse_reg;
        out_data_next[17:2]  = channel_reg;
        out_data_next[18]    = done_flag_reg;
        out_data_next[25:19] = name_len_reg;
        out_data_next[32:26] = key_len_reg;
        out_data_next[33]    = rvalid;
        out_data_next[49:34] = rvalid ? rd_q : 16'd0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_retune_locked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[1] |-> out_data_reg[0])
        else $error("retune without lock");

    a_done_locked: assert property (@(posedge clk) disable iff (!rst_n)
        done_flag_reg |-> lock_flag_reg)
        else $error("complete before lock");

    a_lock_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(lock_flag_reg) |-> $past(state_reg) == ST_EXEC)
        else $error("lock outside execute");

    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_flag_reg) |-> (name_len_reg != 7'd0 || key_len_reg != 7'd0))
        else $error("complete with zero lengths");

endmodule
